### sv/text_console_cursor_scroll_assert.svh
// Assertion macros shared by the console checker.
// No dependencies; included by tccs_checker.sv.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCCS_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCCS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/tccs_pkg.sv
// Shared types and constants for the text console.
// No dependencies; used by the store, the top level, the checker and the testbench.
package tccs_pkg;

  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CHAR    = 8'h0A;
  localparam logic [7:0] BLANK_CHAR      = 8'h20;
  localparam logic [7:0] RESET_ATTRIBUTE = 8'h0F;

  localparam logic [1:0] SWEEP_NONE   = 2'd0;
  localparam logic [1:0] SWEEP_CLEAR  = 2'd1;
  localparam logic [1:0] SWEEP_SCROLL = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  character;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } rsp_t;

  // Control from the command sequencer to the screen store.
  typedef struct packed {
    logic [1:0] sweep;
    logic       wr_en;
    logic       rd_en;
  } store_ctl_t;

endpackage

### sv/tccs_store.sv
// Screen store: cell memory plus the sweep engine for clear, scroll and reset fill.
// Depends on tccs_pkg.
module tccs_store import tccs_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEFAULT_COLUMNS,
  parameter int SCREEN_ROWS    = DEFAULT_ROWS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  store_ctl_t                                    ctl,
  input  logic [$clog2(SCREEN_ROWS*SCREEN_COLUMNS)-1:0] addr,
  input  logic [15:0]                                   wr_data,
  input  logic [15:0]                                   blank,
  output logic                                          busy,
  output logic [15:0]                                   rd_data
);

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [1:0] SW_IDLE  = 2'd0;
  localparam logic [1:0] SW_MOVE  = 2'd1;
  localparam logic [1:0] SW_BLANK = 2'd2;

  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN    = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);

  logic [15:0]       mem [CELL_COUNT];
  logic [1:0]        sw_state;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] mv_addr;
  logic              mv_valid;
  logic [15:0]       blank_q;

  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [15:0]       wd;
  logic              re;
  logic [ADDR_W-1:0] ra;

  assign busy = (sw_state != SW_IDLE) || mv_valid;

  // A pending move lands first; the blank pointer holds meanwhile.
  always_comb begin
    we = 1'b0;
    wa = addr;
    wd = wr_data;
    if (mv_valid) begin
      we = 1'b1;
      wa = mv_addr;
      wd = rd_data;
    end else if (sw_state == SW_BLANK) begin
      we = 1'b1;
      wa = ptr;
      wd = blank_q;
    end else if (ctl.wr_en) begin
      we = 1'b1;
    end
  end

  always_comb begin
    re = ctl.rd_en;
    ra = addr;
    if (sw_state == SW_MOVE) begin
      re = 1'b1;
      ra = ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_state <= SW_BLANK;
      ptr      <= '0;
      mv_valid <= 1'b0;
      blank_q  <= {RESET_ATTRIBUTE, BLANK_CHAR};
    end else begin
      mv_valid <= (sw_state == SW_MOVE);
      mv_addr  <= ptr - ROW_SPAN;
      case (sw_state)
        SW_IDLE: begin
          if (ctl.sweep == SWEEP_CLEAR) begin
            sw_state <= SW_BLANK;
            ptr      <= '0;
            blank_q  <= blank;
          end else if (ctl.sweep == SWEEP_SCROLL) begin
            sw_state <= SW_MOVE;
            ptr      <= ROW_SPAN;
            blank_q  <= blank;
          end
        end
        SW_MOVE: begin
          if (ptr == LAST_ADDR) begin
            sw_state <= SW_BLANK;
            ptr      <= BOTTOM_BASE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        SW_BLANK: begin
          if (!mv_valid) begin
            if (ptr == LAST_ADDR) begin
              sw_state <= SW_IDLE;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        default: begin
          sw_state <= SW_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/text_console_cursor_scroll.sv
// Text console: character-cell screen store with cursor, scroll and clear.
// Channels: req (command, character, cell_index) in, rsp (echo byte, cell, cursor)
// out, both valid/stall; a transaction completes when valid is high and stall low.
// cfg_wr_en/cfg_wr_data write the attribute used for written and blanked cells.
// Every request yields exactly one response, taken from an output register.
// Put without scroll and read: the accepted request moves to ST_EMIT, and the
// response register loads once it is free. A put that runs off the bottom row
// scrolls: each cell below the top row is read and written one row up, one per
// cycle, then the bottom row is blanked. Clear: one blank write per cell.
// One request at a time.
// After reset a fill pass writes every cell blank (attribute 0x0F); req_stall
// stays high until the fill pass ends, while configuration writes are taken at
// any time.
// A stalled response holds; the next request may be accepted while it waits,
// and its response is held back until the output register frees.
// Depends on tccs_pkg and tccs_store.
module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEFAULT_COLUMNS,
  parameter int SCREEN_ROWS    = DEFAULT_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp
);

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state;
  logic [4:0]        cur_row;
  logic [6:0]        cur_col;
  logic [7:0]        attr;
  logic [1:0]        cmd_q;
  logic [7:0]        char_q;
  logic              idx_ok_q;

  logic              accept;
  logic              out_free;
  logic              emit;
  logic              is_nl;
  logic              idx_ok;
  logic              scroll;
  logic [7:0]        col_inc;
  logic [5:0]        row_inc;
  logic [6:0]        col_next;
  logic [5:0]        row_wide;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] st_addr;
  store_ctl_t        ctl;
  logic              busy;
  logic [15:0]       rd_data;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign emit      = (state == ST_EMIT) && out_free;

  assign is_nl    = (req.character == NEWLINE_CHAR);
  assign idx_ok   = {2'b00, req.cell_index} < 13'(CELL_COUNT);
  assign col_inc  = {1'b0, cur_col} + 8'd1;
  assign row_inc  = {1'b0, cur_row} + 6'd1;
  assign cur_addr = ADDR_W'(cur_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(cur_col);

  always_comb begin
    col_next = col_inc[6:0];
    row_wide = {1'b0, cur_row};
    if (is_nl || col_inc == 8'(SCREEN_COLUMNS)) begin
      col_next = '0;
      row_wide = row_inc;
    end
    scroll = (row_wide == 6'(SCREEN_ROWS));
  end

  always_comb begin
    ctl     = '0;
    st_addr = cur_addr;
    if (accept) begin
      case (req.command)
        CMD_PUT: begin
          ctl.wr_en = !is_nl;
          if (scroll) begin
            ctl.sweep = SWEEP_SCROLL;
          end
        end
        CMD_CLEAR: begin
          ctl.sweep = SWEEP_CLEAR;
        end
        CMD_READ: begin
          ctl.rd_en = idx_ok;
          st_addr   = ADDR_W'(req.cell_index);
        end
        default: begin
        end
      endcase
    end
  end

  tccs_store #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .addr    (st_addr),
    .wr_data ({attr, req.character}),
    .blank   ({attr, BLANK_CHAR}),
    .busy    (busy),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cur_row   <= '0;
      cur_col   <= '0;
      attr      <= RESET_ATTRIBUTE;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (!busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (req.command)
              CMD_PUT: begin
                cur_col <= col_next;
                cur_row <= scroll ? 5'(SCREEN_ROWS - 1) : row_wide[4:0];
                state   <= scroll ? ST_WAIT : ST_EMIT;
              end
              CMD_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                state   <= ST_WAIT;
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_WAIT: begin
          // sweep started at the accepting edge, so busy is already up here
          if (!busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= req.command;
      char_q   <= req.character;
      idx_ok_q <= idx_ok;
    end
    if (emit) begin
      rsp.serial_valid  <= (cmd_q == CMD_PUT);
      rsp.serial_byte   <= (cmd_q == CMD_PUT) ? char_q : 8'h00;
      rsp.cell_value    <= (cmd_q == CMD_READ && idx_ok_q) ? rd_data : 16'h0000;
      rsp.cursor_row    <= cur_row;
      rsp.cursor_column <= cur_col;
    end
  end

endmodule

### sv/tccs_checker.sv
// Port-level checks for the text console, bound onto the top level.
// Depends on tccs_pkg and text_console_cursor_scroll_assert.svh.
`include "text_console_cursor_scroll_assert.svh"

module tccs_checker import tccs_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEFAULT_COLUMNS,
  parameter int SCREEN_ROWS    = DEFAULT_ROWS
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // one transaction in flight: an accepted request closes the channel next cycle
  `TCCS_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && !req_stall, req_stall, "request accepted back to back")

  // nothing comes out right after reset
  `TCCS_ASSERT_SAME(a_quiet_after_reset, clk, rst, $fell(rst), !rsp_valid, "response right after reset")

  `TCCS_ASSERT_SAME(a_cursor_range, clk, rst, rsp_valid, ({1'b0, rsp.cursor_row} < 6'(SCREEN_ROWS)) && ({1'b0, rsp.cursor_column} < 8'(SCREEN_COLUMNS)), "cursor out of screen")

  `TCCS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS),
  .SCREEN_ROWS   (SCREEN_ROWS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### tb/tb.sv
// Testbench for text_console_cursor_scroll: directed table, then random console traffic.
// Keeps its own screen/cursor/attribute copy and checks every response transaction.
// Depends on tccs_pkg and the text_console_cursor_scroll RTL.
module tb import tccs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = DEFAULT_COLUMNS;
  localparam int ROWS  = DEFAULT_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam int LIMIT = 2_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    req_t stim;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;

  // Screen model state
  logic [15:0] screen [CELLS];
  int          cur_row, cur_col;
  logic [7:0]  attr_now;

  rsp_t console_rsp_q [$];
  rsp_t want_rsp;
  int   fail_count = 0;
  int   items_done = 0;
  int   burst_left = 1;
  int   cycle_count = 0;
  int   stall_mode = 0;
  int   stall_left = 0;
  logic [7:0] attr_plan [4];

  // Typed rows are read straight off the spec; '0 rows go through the screen model.
  dir_row_t dir_tab [23] = '{
    '{'{CMD_READ,   8'h00, 11'd0},    1'b1, '{1'b0, 8'h00, 16'h0F20, 5'd0, 7'd0}},
    '{'{CMD_READ,   8'hFF, 11'd1999}, 1'b1, '{1'b0, 8'h00, 16'h0F20, 5'd0, 7'd0}},
    '{'{CMD_READ,   8'h00, 11'd2000}, 1'b1, '{1'b0, 8'h00, 16'h0000, 5'd0, 7'd0}},
    '{'{CMD_READ,   8'hFF, 11'd2047}, 1'b1, '{1'b0, 8'h00, 16'h0000, 5'd0, 7'd0}},
    '{'{CMD_UNUSED, 8'hFF, 11'h7FF},  1'b1, '{1'b0, 8'h00, 16'h0000, 5'd0, 7'd0}},
    '{'{CMD_PUT,    8'h00, 11'd0},    1'b1, '{1'b1, 8'h00, 16'h0000, 5'd0, 7'd1}},
    '{'{CMD_PUT,    8'hFF, 11'h7FF},  1'b1, '{1'b1, 8'hFF, 16'h0000, 5'd0, 7'd2}},
    '{'{CMD_PUT,    8'h80, 11'd0},    1'b1, '{1'b1, 8'h80, 16'h0000, 5'd0, 7'd3}},
    '{'{CMD_PUT,    8'h7F, 11'h400},  1'b1, '{1'b1, 8'h7F, 16'h0000, 5'd0, 7'd4}},
    '{'{CMD_READ,   8'h00, 11'd0},    1'b1, '{1'b0, 8'h00, 16'h0F00, 5'd0, 7'd4}},
    '{'{CMD_READ,   8'h00, 11'd1},    1'b1, '{1'b0, 8'h00, 16'h0FFF, 5'd0, 7'd4}},
    '{'{CMD_READ,   8'h00, 11'd2},    1'b1, '{1'b0, 8'h00, 16'h0F80, 5'd0, 7'd4}},
    '{'{CMD_PUT,    8'h0A, 11'd0},    1'b1, '{1'b1, 8'h0A, 16'h0000, 5'd1, 7'd0}},
    '{'{CMD_PUT,    8'h41, 11'd5},    1'b0, '0},
    '{'{CMD_READ,   8'h00, 11'd80},   1'b0, '0},
    '{'{CMD_UNUSED, 8'h0A, 11'd0},    1'b0, '0},
    '{'{CMD_PUT,    8'h0A, 11'd3},    1'b0, '0},
    '{'{CMD_READ,   8'hAA, 11'd4},    1'b0, '0},
    '{'{CMD_CLEAR,  8'hFF, 11'h7FF},  1'b1, '{1'b0, 8'h00, 16'h0000, 5'd0, 7'd0}},
    '{'{CMD_READ,   8'h00, 11'd0},    1'b1, '{1'b0, 8'h00, 16'h0F20, 5'd0, 7'd0}},
    '{'{CMD_READ,   8'h00, 11'd80},   1'b1, '{1'b0, 8'h00, 16'h0F20, 5'd0, 7'd0}},
    '{'{CMD_PUT,    8'h20, 11'd0},    1'b0, '0},
    '{'{CMD_READ,   8'h00, 11'd0},    1'b0, '0}
  };

  text_console_cursor_scroll i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("text_console_cursor_scroll verification failed");
      $finish;
    end
  end

  // Receiver stall pattern: a random mode, redrawn whenever its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 7) == 0);
      2: rsp_stall <= 1'($urandom_range(0, 1));
      default: rsp_stall <= (stall_left % 6 < 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (console_rsp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected response transaction: %p", rsp);
      end else begin
        want_rsp = console_rsp_q.pop_front();
        if (rsp.serial_valid !== want_rsp.serial_valid ||
            rsp.serial_byte !== want_rsp.serial_byte ||
            rsp.cell_value !== want_rsp.cell_value ||
            rsp.cursor_row !== want_rsp.cursor_row ||
            rsp.cursor_column !== want_rsp.cursor_column) begin
          fail_count++;
          if (fail_count <= 10)
            $display("response mismatch: expected %p, got %p", want_rsp, rsp);
        end
      end
    end
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++)
      screen[i] = {attr_now, BLANK_CHAR};
  endfunction

  function automatic rsp_t console_apply(req_t r);
    rsp_t o;
    o = '0;
    case (r.command)
      CMD_PUT: begin
        o.serial_valid = 1'b1;
        o.serial_byte  = r.character;
        if (r.character == NEWLINE_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen[cur_row * COLS + cur_col] = {attr_now, r.character};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // ran off the bottom: scroll up one line
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLS; i++)
            screen[i] = screen[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++)
            screen[i] = {attr_now, BLANK_CHAR};
          cur_row = ROWS - 1;
        end
      end
      CMD_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      CMD_READ: begin
        if (r.cell_index < CELLS)
          o.cell_value = screen[r.cell_index];
      end
      default: ;
    endcase
    o.cursor_row    = cur_row[4:0];
    o.cursor_column = cur_col[6:0];
    return o;
  endfunction

  function automatic req_t pack_req(logic [1:0] c, logic [7:0] ch, logic [10:0] idx);
    req_t r;
    r.command    = c;
    r.character  = ch;
    r.cell_index = idx;
    return r;
  endfunction

  task automatic pace();
    int gap;
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_item(input req_t item, input bit typed, input rsp_t want);
    rsp_t guess;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    guess = console_apply(item);
    console_rsp_q.push_back(typed ? want : guess);
    if (item.command != CMD_UNUSED)
      items_done++;
    pace();
  endtask

  task automatic wait_results();
    req_valid <= 1'b0;
    while (console_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [7:0] v);
    wait_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    attr_now = v;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_console_traffic(input int target);
    int stop_at, n, t;
    logic [7:0] ch;
    stop_at = items_done + target;
    while (items_done < stop_at) begin
      t = $urandom_range(0, 99);
      if (t < 60) begin
        // a line of text, sometimes long enough to wrap
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 30);
        repeat (n) begin
          ch = 8'($urandom_range(0, 255));
          if (ch == NEWLINE_CHAR)
            ch = BLANK_CHAR;
          send_item(pack_req(CMD_PUT, ch, 11'($urandom_range(0, 2047))), 1'b0, '0);
        end
        if ($urandom_range(0, 3) != 0)
          send_item(pack_req(CMD_PUT, NEWLINE_CHAR, 11'($urandom_range(0, 2047))),
                    1'b0, '0);
      end else if (t < 90) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: n = $urandom_range(0, 2047);
            1: begin
              n = cur_row * COLS + cur_col - $urandom_range(0, 3);
              if (n < 0)
                n = 0;
            end
            2: n = (ROWS - 1) * COLS + $urandom_range(0, COLS - 1);
            default: n = $urandom_range(0, 1) ? $urandom_range(0, COLS) :
                                                $urandom_range(CELLS - COLS - 1, CELLS);
          endcase
          send_item(pack_req(CMD_READ, 8'($urandom_range(0, 255)), n[10:0]), 1'b0, '0);
        end
      end else if (t < 98) begin
        repeat ($urandom_range(1, 3))
          send_item(pack_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047))), 1'b0, '0);
      end else begin
        send_item(pack_req(CMD_CLEAR, 8'($urandom_range(0, 255)),
                           11'($urandom_range(0, 2047))), 1'b0, '0);
      end
    end
  endtask

  initial begin
    attr_now = RESET_ATTRIBUTE;
    blank_screen();
    cur_row = 0;
    cur_col = 0;
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = 8'($urandom_range(1, 254));
    attr_plan[3] = 8'($urandom_range(0, 255));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);

    // attribute changes leave old cells alone, so no clear between phases
    for (int p = 0; p < 4; p++) begin
      set_attribute(attr_plan[p]);
      run_console_traffic(450);
    end

    wait_results();
    repeat (CELLS + 100) @(posedge clk);
    if (fail_count == 0)
      $display("text_console_cursor_scroll verification clean");
    else
      $display("text_console_cursor_scroll verification failed");
    $finish;
  end

endmodule

### text_console_cursor_scroll.f
+incdir+sv
sv/tccs_pkg.sv
sv/tccs_store.sv
sv/text_console_cursor_scroll.sv
sv/tccs_checker.sv
tb/tb.sv
